### design/assert_macros.svh
// Assertion helpers for the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Check that an antecedent is followed by a consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

### design/isearch_pkg.sv
`timescale 1ns / 1ps

package isearch_pkg;

    localparam int GROUPS      = 26;
    localparam int RECORDS     = 4096;
    localparam int KEY_BYTES   = 5;
    localparam int LETTER_BASE = 65;

    // Port widths
    localparam int MODE_W  = 2;
    localparam int GROUP_W = 5;
    localparam int COUNT_W = 13;
    localparam int ADDR_W  = 12;
    localparam int KEY_W   = 8 * KEY_BYTES;

    // Internal widths
    localparam int GRP_IDX_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int REC_IDX_W = $clog2(RECORDS);
    localparam int STEP_W    = 4;

    localparam logic [MODE_W-1:0] MODE_WR_COUNT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WR_KEY   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOOKUP   = 2'd2;

    // Microprogram step addresses
    localparam logic [STEP_W-1:0] STEP_IDLE      = 4'd0;
    localparam logic [STEP_W-1:0] STEP_DISPATCH  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_WR_COUNT  = 4'd2;  // dispatch base + mode 0
    localparam logic [STEP_W-1:0] STEP_WR_KEY    = 4'd3;
    localparam logic [STEP_W-1:0] STEP_LOOKUP    = 4'd4;
    localparam logic [STEP_W-1:0] STEP_UNUSED    = 4'd5;
    localparam logic [STEP_W-1:0] STEP_WALK      = 4'd6;
    localparam logic [STEP_W-1:0] STEP_SCAN_INIT = 4'd7;
    localparam logic [STEP_W-1:0] STEP_READ      = 4'd8;
    localparam logic [STEP_W-1:0] STEP_CMP       = 4'd9;
    localparam logic [STEP_W-1:0] STEP_RESULT    = 4'd10;

    typedef enum logic [3:0] {
        OP_NONE      = 4'd0,
        OP_WR_COUNT  = 4'd1,
        OP_WR_KEY    = 4'd2,
        OP_INIT      = 4'd3,
        OP_WALK      = 4'd4,
        OP_SCAN_INIT = 4'd5,
        OP_READ      = 4'd6,
        OP_CMP       = 4'd7,
        OP_RESULT    = 4'd8
    } op_t;

    // Jump to jump_to (+ mode on COND_MODE) if the condition holds, else next_to.
    typedef enum logic [2:0] {
        COND_ALWAYS    = 3'd0,
        COND_ACCEPT    = 3'd1,
        COND_MODE      = 3'd2,
        COND_WALK_DONE = 3'd3,
        COND_SCAN_END  = 3'd4,
        COND_MISS      = 3'd5,
        COND_OUT_BUSY  = 3'd6
    } cond_t;

    typedef struct packed {
        logic              ready;
        op_t               op;
        cond_t             cond;
        logic [STEP_W-1:0] jump_to;
        logic [STEP_W-1:0] next_to;
    } ctrl_word_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              walk_done;
        logic              scan_end;
        logic              miss;
        logic              out_busy;
    } dp_status_t;

    function automatic ctrl_word_t mk(input logic ready, input op_t op, input cond_t cond,
                                      input logic [STEP_W-1:0] jump_to,
                                      input logic [STEP_W-1:0] next_to);
        ctrl_word_t w;
        w.ready   = ready;
        w.op      = op;
        w.cond    = cond;
        w.jump_to = jump_to;
        w.next_to = next_to;
        return w;
    endfunction

    // Control store
    function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
        ctrl_word_t w;
        unique case (step)
            STEP_IDLE:      w = mk(1'b1, OP_NONE, COND_ACCEPT, STEP_DISPATCH, STEP_IDLE);
            STEP_DISPATCH:  w = mk(1'b0, OP_NONE, COND_MODE, STEP_WR_COUNT, STEP_IDLE);
            STEP_WR_COUNT:  w = mk(1'b0, OP_WR_COUNT, COND_ALWAYS, STEP_IDLE, STEP_IDLE);
            STEP_WR_KEY:    w = mk(1'b0, OP_WR_KEY, COND_ALWAYS, STEP_IDLE, STEP_IDLE);
            STEP_LOOKUP:    w = mk(1'b0, OP_INIT, COND_ALWAYS, STEP_WALK, STEP_WALK);
            STEP_UNUSED:    w = mk(1'b0, OP_NONE, COND_ALWAYS, STEP_IDLE, STEP_IDLE);
            STEP_WALK:      w = mk(1'b0, OP_WALK, COND_WALK_DONE, STEP_SCAN_INIT, STEP_WALK);
            STEP_SCAN_INIT: w = mk(1'b0, OP_SCAN_INIT, COND_ALWAYS, STEP_READ, STEP_READ);
            STEP_READ:      w = mk(1'b0, OP_READ, COND_SCAN_END, STEP_RESULT, STEP_CMP);
            STEP_CMP:       w = mk(1'b0, OP_CMP, COND_MISS, STEP_READ, STEP_RESULT);
            STEP_RESULT:    w = mk(1'b0, OP_RESULT, COND_OUT_BUSY, STEP_RESULT, STEP_IDLE);
            default:        w = mk(1'b0, OP_NONE, COND_ALWAYS, STEP_IDLE, STEP_IDLE);
        endcase
        return w;
    endfunction

endpackage

### design/isearch_ram.sv
`timescale 1ns / 1ps

module isearch_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/isearch_seq.sv
`timescale 1ns / 1ps

module isearch_seq (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    input  isearch_pkg::dp_status_t st,
    output isearch_pkg::ctrl_word_t ctrl
);
    import isearch_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              taken;

    assign ctrl = ucode(step_reg);

    always_comb begin
        taken = 1'b0;
        unique case (ctrl.cond)
            COND_ALWAYS:    taken = 1'b1;
            COND_ACCEPT:    taken = s_valid && ctrl.ready;
            COND_MODE:      taken = 1'b1;
            COND_WALK_DONE: taken = st.walk_done;
            COND_SCAN_END:  taken = st.scan_end;
            COND_MISS:      taken = st.miss;
            COND_OUT_BUSY:  taken = st.out_busy;
            default:        taken = 1'b1;
        endcase
    end

    always_comb begin
        if (ctrl.cond == COND_MODE) begin
            // Multi-way branch: one slot per mode code
            step_next = ctrl.jump_to + STEP_W'(st.mode);
        end else if (taken) begin
            step_next = ctrl.jump_to;
        end else begin
            step_next = ctrl.next_to;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

### design/isearch_dp.sv
`timescale 1ns / 1ps

module isearch_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  isearch_pkg::ctrl_word_t              ctrl,
    input  logic                                 s_valid,
    input  logic [isearch_pkg::MODE_W-1:0]       s_mode,
    input  logic [isearch_pkg::GROUP_W-1:0]      s_group,
    input  logic [isearch_pkg::COUNT_W-1:0]      s_count,
    input  logic [isearch_pkg::ADDR_W-1:0]       s_address,
    input  logic [isearch_pkg::KEY_W-1:0]        s_key,
    output isearch_pkg::dp_status_t              st,
    input  logic                                 m_ready,
    output logic                                 m_valid,
    output logic                                 m_found,
    output logic [isearch_pkg::ADDR_W-1:0]       m_position,
    output logic [isearch_pkg::COUNT_W-1:0]      m_range_start,
    output logic [isearch_pkg::COUNT_W-1:0]      m_range_count
);
    import isearch_pkg::*;

    // Captured item
    logic [MODE_W-1:0]    mode_reg;
    logic [GROUP_W-1:0]   group_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [KEY_W-1:0]     key_reg;

    // Group table and search state
    logic [COUNT_W-1:0]   counts_reg [GROUPS];
    logic [GRP_IDX_W-1:0] g_reg;
    logic [COUNT_W-1:0]   start_reg;
    logic [COUNT_W-1:0]   rcount_reg;
    logic [COUNT_W-1:0]   end_reg;
    logic [COUNT_W-1:0]   idx_reg;
    logic                 found_reg;
    logic [ADDR_W-1:0]    pos_reg;

    // Result register
    logic                 m_valid_reg;
    logic                 m_found_reg;
    logic [ADDR_W-1:0]    m_position_reg;
    logic [COUNT_W-1:0]   m_start_reg;
    logic [COUNT_W-1:0]   m_count_reg;

    logic                 accept;
    logic [7:0]           lead;
    logic [7:0]           lead_off;
    logic                 slot_ok;
    logic [GRP_IDX_W-1:0] slot;
    logic [COUNT_W-1:0]   cnt_cur;
    logic                 hit;
    logic [COUNT_W:0]     start_sum;
    logic [COUNT_W:0]     end_sum;
    logic [COUNT_W-1:0]   count_sat;
    logic [GRP_IDX_W-1:0] wr_slot;
    logic                 out_busy;
    logic                 out_load;
    logic [KEY_W-1:0]     rdata;
    logic                 miss;
    logic                 scan_end;

    assign accept = s_valid && ctrl.ready;

    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg  <= s_mode;
            group_reg <= s_group;
            count_reg <= s_count;
            addr_reg  <= s_address;
            key_reg   <= s_key;
        end
    end

    // Leading character selects the group
    assign lead     = key_reg[KEY_W-1 -: 8];
    assign lead_off = lead - 8'(LETTER_BASE);
    assign slot_ok  = (lead >= 8'(LETTER_BASE)) && (32'(lead_off) < GROUPS);
    assign slot     = GRP_IDX_W'(lead_off);

    assign cnt_cur   = counts_reg[g_reg];
    assign hit       = slot_ok && (g_reg == slot);
    assign start_sum = {1'b0, start_reg} + {1'b0, cnt_cur};
    assign end_sum   = {1'b0, start_reg} + {1'b0, rcount_reg};
    assign count_sat = (32'(count_reg) > RECORDS) ? COUNT_W'(RECORDS) : count_reg;
    assign wr_slot   = GRP_IDX_W'(group_reg);

    // Group table write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < GROUPS; i++) begin
                counts_reg[i] <= '0;
            end
        end else if (ctrl.op == OP_WR_COUNT && 32'(group_reg) < GROUPS) begin
            counts_reg[wr_slot] <= count_sat;
        end
    end

    isearch_ram #(
        .WIDTH(KEY_W),
        .DEPTH(RECORDS)
    ) u_keys (
        .aclk (aclk),
        .we   (ctrl.op == OP_WR_KEY && 32'(addr_reg) < RECORDS),
        .waddr(REC_IDX_W'(addr_reg)),
        .wdata(key_reg),
        .re   (ctrl.op == OP_READ && !scan_end),
        .raddr(idx_reg[REC_IDX_W-1:0]),
        .rdata(rdata)
    );

    assign scan_end = (idx_reg >= end_reg);
    assign miss     = (rdata != key_reg);

    // Search registers
    always_ff @(posedge aclk) begin
        unique case (ctrl.op)
            OP_INIT: begin
                g_reg      <= '0;
                start_reg  <= '0;
                rcount_reg <= '0;
                found_reg  <= 1'b0;
                pos_reg    <= '0;
            end
            OP_WALK: begin
                if (hit) begin
                    rcount_reg <= cnt_cur;
                end else begin
                    // saturate the running start at the store size
                    start_reg <= (32'(start_sum) > RECORDS) ? COUNT_W'(RECORDS)
                                                           : start_sum[COUNT_W-1:0];
                    if (g_reg != GRP_IDX_W'(GROUPS - 1)) begin
                        g_reg <= g_reg + 1'b1;
                    end
                end
            end
            OP_SCAN_INIT: begin
                end_reg <= (32'(end_sum) > RECORDS) ? COUNT_W'(RECORDS)
                                                    : end_sum[COUNT_W-1:0];
                idx_reg <= start_reg;
            end
            OP_CMP: begin
                if (miss) begin
                    idx_reg <= idx_reg + 1'b1;
                end else begin
                    found_reg <= 1'b1;
                    pos_reg   <= ADDR_W'(idx_reg);
                end
            end
            default: begin
            end
        endcase
    end

    // Output register
    assign out_busy = m_valid_reg && !m_ready;
    assign out_load = (ctrl.op == OP_RESULT) && !out_busy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_found_reg    <= found_reg;
            m_position_reg <= pos_reg;
            m_start_reg    <= start_reg;
            m_count_reg    <= rcount_reg;
        end
    end

    assign st.mode      = mode_reg;
    assign st.walk_done = hit || (g_reg == GRP_IDX_W'(GROUPS - 1));
    assign st.scan_end  = scan_end;
    assign st.miss      = miss;
    assign st.out_busy  = out_busy;

    assign m_valid       = m_valid_reg;
    assign m_found       = m_found_reg;
    assign m_position    = m_position_reg;
    assign m_range_start = m_start_reg;
    assign m_range_count = m_count_reg;

endmodule

### design/indexed_sequential_search.sv
// Writes: a count or key write is accepted, dispatched and written, then the block is idle again.
// Lookup: dispatch, clear the search state, walk the 26 groups until the key's group or the last
// one, then scan the range (clipped at the store), reading then comparing each record until a
// match or the range end, and load the result register once it has room. One item at a time:
// a new item is taken only in the idle step; a lookup waits while the result register is full.
// Reset: aresetn (synchronous, active low) clears group counts, step counter, result valid.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module indexed_sequential_search (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [isearch_pkg::MODE_W-1:0]   s_mode,
    input  logic [isearch_pkg::GROUP_W-1:0]  s_group,
    input  logic [isearch_pkg::COUNT_W-1:0]  s_count,
    input  logic [isearch_pkg::ADDR_W-1:0]   s_address,
    input  logic [isearch_pkg::KEY_W-1:0]    s_key,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_found,
    output logic [isearch_pkg::ADDR_W-1:0]   m_position,
    output logic [isearch_pkg::COUNT_W-1:0]  m_range_start,
    output logic [isearch_pkg::COUNT_W-1:0]  m_range_count
);
    import isearch_pkg::*;

    // Control word of the current microprogram step and the datapath flags
    // that its conditional jumps test.
    ctrl_word_t ctrl;
    dp_status_t st;

    // Reported position lies inside the reported range.
    logic       hit_in_range;

    // Sequencer: step counter plus control store. It idles with ready high,
    // dispatches on the captured mode, loops on the group walk and on the
    // record scan, then waits for room in the result register.
    isearch_seq u_seq (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .st     (st),
        .ctrl   (ctrl)
    );

    // Datapath: item capture, group table, record store, search counters and
    // the result register that decouples the two channels.
    isearch_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (ctrl),
        .s_valid      (s_valid),
        .s_mode       (s_mode),
        .s_group      (s_group),
        .s_count      (s_count),
        .s_address    (s_address),
        .s_key        (s_key),
        .st           (st),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_found      (m_found),
        .m_position   (m_position),
        .m_range_start(m_range_start),
        .m_range_count(m_range_count)
    );

    // Take a new item only in the idle step.
    assign s_ready = ctrl.ready;

    assign hit_in_range = (13'(m_position) >= m_range_start)
                       && (14'(m_position) < 14'(m_range_start) + 14'(m_range_count));

    // One item at a time: drop ready right after an acceptance.
    `ASSERT_NEXT(a_one_item, s_valid && s_ready, !s_ready, "ready stayed high after accept")

    // A new result comes only from a lookup.
    `ASSERT_CLK(a_lookup_only, $rose(m_valid) |-> st.mode == MODE_LOOKUP, "result without lookup")

    // A hit lies inside the reported range.
    `ASSERT_CLK(a_hit_in_range, (m_valid && m_found) |-> hit_in_range, "hit outside range")

endmodule

### tb/sv/tb_indexed_sequential_search.sv
`timescale 1ns / 1ps

module tb_indexed_sequential_search;
    import isearch_pkg::*;

    // Mode 3 has no meaning in the block; the item is dropped.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam int IDLE_PCT          = 27;
    localparam int QUIET_LIMIT       = 40000;
    localparam int STALL_CYCLES      = 300;
    localparam int ITEM_TARGET       = 1000;
    localparam int LOOKUPS_PER_PHASE = 40;
    localparam int DRAIN_CYCLES      = 64;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [MODE_W-1:0]    s_mode;
    logic [GROUP_W-1:0]   s_group;
    logic [COUNT_W-1:0]   s_count;
    logic [ADDR_W-1:0]    s_address;
    logic [KEY_W-1:0]     s_key;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_found;
    logic [ADDR_W-1:0]    m_position;
    logic [COUNT_W-1:0]   m_range_start;
    logic [COUNT_W-1:0]   m_range_count;

    typedef struct {
        logic               found;
        logic [ADDR_W-1:0]  position;
        logic [COUNT_W-1:0] range_start;
        logic [COUNT_W-1:0] range_count;
    } lookup_answer_t;

    // Shadow copy of the group table and the record store.
    logic [COUNT_W-1:0] grp_count [GROUPS];
    logic [KEY_W-1:0]   rec_key [RECORDS];
    bit                 rec_written [RECORDS];

    lookup_answer_t pending_answers [$];

    int error_count   = 0;
    int work_items    = 0;
    bit no_idle       = 1'b0;
    bit stall_request = 1'b0;

    indexed_sequential_search dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_group       (s_group),
        .s_count       (s_count),
        .s_address     (s_address),
        .s_key         (s_key),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_position    (m_position),
        .m_range_start (m_range_start),
        .m_range_count (m_range_count)
    );

    always #2 aclk = ~aclk;

    // Compute the answer to a lookup from the shadow tables. Flag any scan
    // that would read a record slot that was never written.
    function automatic lookup_answer_t search_groups(input logic [KEY_W-1:0] key,
                                                     output bit touches_unwritten);
        lookup_answer_t a;
        int lead;
        int slot;
        int start;
        int span;
        int stop;
        int g;
        int i;
        lead = key[KEY_W-1 -: 8];
        slot = GROUPS;
        if (lead >= LETTER_BASE && lead - LETTER_BASE < GROUPS) begin
            slot = lead - LETTER_BASE;
        end
        // Sum every group ahead of the slot; a non-letter sums the whole table.
        start = 0;
        for (g = 0; g < slot; g++) begin
            start += grp_count[g];
        end
        span = (slot < GROUPS) ? int'(grp_count[slot]) : 0;
        if (start > RECORDS) begin
            start = RECORDS;
        end
        // Clip the compared range at the store, but report the count unclipped.
        stop = (start + span > RECORDS) ? RECORDS : start + span;
        a.found = 1'b0;
        a.position = '0;
        touches_unwritten = 1'b0;
        for (i = start; i < stop && !a.found; i++) begin
            if (!rec_written[i]) begin
                touches_unwritten = 1'b1;
            end
            if (rec_key[i] == key) begin
                a.found = 1'b1;
                a.position = ADDR_W'(i);
            end
        end
        a.range_start = COUNT_W'(start);
        a.range_count = COUNT_W'(span);
        return a;
    endfunction

    function automatic int group_base(input int g);
        int sum;
        int j;
        sum = 0;
        for (j = 0; j < g; j++) begin
            sum += grp_count[j];
        end
        return sum;
    endfunction

    function automatic logic [KEY_W-1:0] rand_key();
        return {8'($urandom), 32'($urandom)};
    endfunction

    // Pick a leading byte outside A to Z.
    function automatic logic [7:0] non_letter();
        int r;
        if ($urandom_range(1) == 1) begin
            r = $urandom_range(0, LETTER_BASE - 1);
        end else begin
            r = $urandom_range(LETTER_BASE + GROUPS, 255);
        end
        return 8'(r);
    endfunction

    // Offer one item, entered and left at a falling edge. Idle at random
    // first, hold the payload until accepted, then fold the item into the
    // shadow tables.
    task automatic offer_item(input logic [MODE_W-1:0] mode, input logic [GROUP_W-1:0] group,
                              input logic [COUNT_W-1:0] count,
                              input logic [ADDR_W-1:0] address,
                              input logic [KEY_W-1:0] key);
        bit unused_flag;
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_mode    <= mode;
        s_group   <= group;
        s_count   <= count;
        s_address <= address;
        s_key     <= key;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        case (mode)
            MODE_WR_COUNT: begin
                // Saturate the count at the store size; drop slots past the table.
                if (group < GROUPS) begin
                    grp_count[group] = (count > RECORDS) ? COUNT_W'(RECORDS) : count;
                end
            end
            MODE_WR_KEY: begin
                if (address < RECORDS) begin
                    rec_key[address] = key;
                    rec_written[address] = 1'b1;
                end
            end
            MODE_LOOKUP: begin
                pending_answers.push_back(search_groups(key, unused_flag));
            end
            default: begin
            end
        endcase
        if (mode != MODE_UNUSED && !(mode == MODE_WR_COUNT && group >= GROUPS)) begin
            work_items++;
        end
        @(negedge aclk);
    endtask

    task automatic write_count(input logic [GROUP_W-1:0] group, input logic [COUNT_W-1:0] count);
        offer_item(MODE_WR_COUNT, group, count, 12'($urandom), rand_key());
    endtask

    task automatic write_record(input logic [ADDR_W-1:0] address, input logic [KEY_W-1:0] key);
        offer_item(MODE_WR_KEY, 5'($urandom), 13'($urandom), address, key);
    endtask

    // Send a lookup. Swap the leading byte for a non-letter if the scan would
    // reach a record slot that holds nothing yet.
    task automatic lookup(input logic [KEY_W-1:0] key);
        bit unsafe;
        void'(search_groups(key, unsafe));
        if (unsafe) begin
            key[KEY_W-1 -: 8] = non_letter();
        end
        offer_item(MODE_LOOKUP, 5'($urandom), 13'($urandom), 12'($urandom), key);
    endtask

    // One traffic round: reprogram some or all groups with small counts, fill the
    // covered record range, then mix hits, misses, rewrites and noise.
    task automatic run_phase(input bit rewrite_all);
        int g;
        int i;
        int lo;
        int r;
        int pos;
        logic [KEY_W-1:0] k;
        for (g = 0; g < GROUPS; g++) begin
            if (rewrite_all || $urandom_range(1) == 1) begin
                r = $urandom_range(99);
                write_count(GROUP_W'(g),
                            COUNT_W'((r < 55) ? 0 :
                                     (r < 92) ? $urandom_range(1, 6) : $urandom_range(7, 24)));
            end
        end
        // Fill every slot the groups cover, so no scan reads an empty slot.
        lo = 0;
        for (g = 0; g < GROUPS; g++) begin
            for (i = lo; i < lo + grp_count[g] && i < RECORDS; i++) begin
                if (!rec_written[i] || $urandom_range(99) < 60) begin
                    r = $urandom_range(99);
                    if (r < 10 && i > lo) begin
                        // Repeat an earlier key of the group to check first match.
                        k = rec_key[lo + $urandom_range(i - lo - 1)];
                    end else if (r < 22) begin
                        k = rand_key();
                    end else begin
                        k = {8'(LETTER_BASE + g), 32'($urandom)};
                    end
                    write_record(ADDR_W'(i), k);
                end
            end
            lo += grp_count[g];
        end
        repeat (LOOKUPS_PER_PHASE) begin
            r = $urandom_range(99);
            g = $urandom_range(GROUPS - 1);
            repeat (8) begin
                if (grp_count[g] == 0) begin
                    g = $urandom_range(GROUPS - 1);
                end
            end
            if (r < 45 && grp_count[g] != 0) begin
                lookup(rec_key[group_base(g) + $urandom_range(grp_count[g] - 1)]);
            end else if (r < 55 && grp_count[g] != 0) begin
                // Overwrite a record, then look up the new key.
                pos = group_base(g) + $urandom_range(grp_count[g] - 1);
                k = {rec_key[pos][KEY_W-1 -: 8], 32'($urandom)};
                write_record(ADDR_W'(pos), k);
                lookup(k);
            end else if (r < 75) begin
                lookup({8'(LETTER_BASE + g), 32'($urandom)});
            end else if (r < 83) begin
                lookup({non_letter(), 32'($urandom)});
            end else if (r < 91) begin
                offer_item(MODE_UNUSED, 5'($urandom), 13'($urandom), 12'($urandom), rand_key());
            end else if (r < 95) begin
                write_count(5'($urandom_range(GROUPS, 31)), 13'($urandom));
            end else begin
                lookup(rand_key());
            end
        end
    endtask

    // Lookups against a cleared table: letters at both ends and non-letters.
    task automatic test_empty_table();
        lookup({8'(LETTER_BASE), 32'h0});
        lookup({8'(LETTER_BASE + GROUPS - 1), 32'hFFFF_FFFF});
        lookup('0);
        lookup('1);
    endtask

    // Unused mode and group slots past the table must leave the table alone.
    task automatic test_ignored_items();
        offer_item(MODE_UNUSED, '1, '1, '1, '1);
        write_count(GROUP_W'(GROUPS), COUNT_W'(7));
        write_count('1, '1);
        lookup({8'(LETTER_BASE + GROUPS), 32'($urandom)});
    endtask

    // Push a group's range across the end of the store.
    task automatic test_range_past_store();
        logic [KEY_W-1:0] target;
        int i;
        write_count('0, COUNT_W'(RECORDS - 6));
        write_count(GROUP_W'(1), COUNT_W'(20));
        for (i = RECORDS - 6; i < RECORDS; i++) begin
            write_record(ADDR_W'(i), {8'(LETTER_BASE + 1), 32'($urandom)});
        end
        target = {8'(LETTER_BASE + 1), 32'($urandom)};
        write_record(ADDR_W'(RECORDS - 3), target);
        write_record(ADDR_W'(RECORDS - 1), target);
        lookup(target);
        lookup({8'(LETTER_BASE + 1), ~target[31:0]});
        write_record('0, {8'(LETTER_BASE), 32'($urandom)});
        lookup(rec_key[0]);
    endtask

    // A count above the store size saturates, and so does the range start.
    task automatic test_count_saturation();
        write_count('0, '1);
        lookup(rec_key[0]);
        lookup({8'(LETTER_BASE + 2), 32'($urandom)});
        lookup({8'(LETTER_BASE - 1), 32'($urandom)});
    endtask

    // Drive with no gaps on either side for a whole round.
    task automatic test_back_to_back();
        no_idle = 1'b1;
        run_phase(1'b1);
        no_idle = 1'b0;
    endtask

    // Hold off the result side for a long stretch while items keep coming.
    task automatic test_output_stall();
        stall_request = 1'b1;
        run_phase(1'b0);
    endtask

    task automatic test_random_traffic();
        while (work_items < ITEM_TARGET) begin
            run_phase(1'b0);
        end
    endtask

    // Result side: idle at random, hold off when asked, else ready under no_idle.
    initial begin
        int hold_left;
        hold_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_request) begin
                hold_left = STALL_CYCLES;
                stall_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (no_idle) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Compare each result with the oldest expected answer.
    always @(posedge aclk) begin
        lookup_answer_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_answers.size() == 0) begin
                $error("result with no lookup pending: found %0d position %0d",
                       m_found, m_position);
                error_count++;
            end else begin
                want = pending_answers.pop_front();
                if (m_found !== want.found) begin
                    $error("found: expected %0d, actual %0d", want.found, m_found);
                    error_count++;
                end
                if (m_position !== want.position) begin
                    $error("position: expected %0d, actual %0d", want.position, m_position);
                    error_count++;
                end
                if (m_range_start !== want.range_start) begin
                    $error("range_start: expected %0d, actual %0d",
                           want.range_start, m_range_start);
                    error_count++;
                end
                if (m_range_count !== want.range_count) begin
                    $error("range_count: expected %0d, actual %0d",
                           want.range_count, m_range_count);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no item moves on either side for too long.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        @(posedge aresetn);
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("tb_indexed_sequential_search: done, errors");
        $finish;
    end

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_mode    = MODE_WR_COUNT;
        s_group   = '0;
        s_count   = '0;
        s_address = '0;
        s_key     = '0;
        for (int g = 0; g < GROUPS; g++) begin
            grp_count[g] = '0;
        end
        for (int i = 0; i < RECORDS; i++) begin
            rec_key[i] = '0;
            rec_written[i] = 1'b0;
        end
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_table();
        test_ignored_items();
        test_range_past_store();
        test_count_saturation();
        test_back_to_back();
        test_output_stall();
        test_random_traffic();

        // Drop valid, wait for every answer, then let a trailing write settle.
        s_valid <= 1'b0;
        while (pending_answers.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb_indexed_sequential_search: done, clean");
        end else begin
            $display("tb_indexed_sequential_search: done, errors");
        end
        $finish;
    end

endmodule

### files.f
+incdir+design
design/isearch_pkg.sv
design/isearch_ram.sv
design/isearch_seq.sv
design/isearch_dp.sv
design/indexed_sequential_search.sv
tb/sv/tb_indexed_sequential_search.sv
